/* src/assert_macros.svh */
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* src/rrts_pkg.sv */
package rrts_pkg;

    // request opcodes
    typedef enum logic [2:0] {
        OP_TICK     = 3'd0,
        OP_ADD      = 3'd1,
        OP_REMOVE   = 3'd2,
        OP_BLOCK    = 3'd3,
        OP_RUNNABLE = 3'd4,
        OP_DEAD     = 3'd5,
        OP_RSVD6    = 3'd6,
        OP_RSVD7    = 3'd7
    } op_t;

    // task status codes
    localparam logic [1:0] TS_READY = 2'd0;
    localparam logic [1:0] TS_WAIT  = 2'd1;
    localparam logic [1:0] TS_DEAD  = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_PREV_RD, S_PREV_WR, S_CUR_RD, S_CUR_WR,
        S_WALK_RD, S_WALK_CHK, S_TICK_END, S_ADD, S_S_RD, S_RM_SNEXT,
        S_P_RD, S_P_CHK, S_RM_CLEAR, S_MARK_WR, S_FINISH
    } state_t;

    typedef enum logic [4:0] {
        ACT_NONE, ACT_LOAD, ACT_DECODE, ACT_PREV_RD, ACT_PREV_WR, ACT_CUR_RD,
        ACT_CUR_WR, ACT_WALK_RD, ACT_WALK_CHK, ACT_TICK_END, ACT_ADD, ACT_S_RD,
        ACT_RM_SNEXT, ACT_P_RD, ACT_P_CHK, ACT_RM_CLEAR, ACT_MARK_WR, ACT_RESULT
    } act_t;

    typedef struct packed {
        act_t act;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic cpu_ok;
        logic s_ok;
        logic in_list_s;
        logic head_is_s;
        logic prev_release;
        logic cur_task;
        logic t_valid;
        logic walk_found;
        logic walk_end;
        logic p_valid;
        logic p_hit;
        logic p_end;
        logic out_free;
    } sts_t;

endpackage

/* src/rrts_ram.sv */
module rrts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/rrts_ctrl.sv */
module rrts_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  rrts_pkg::sts_t sts,
    output rrts_pkg::cmd_t cmd
);
    import rrts_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

    // next state and datapath commands
    always_comb begin
        state_next = state_reg;
        cmd.act    = ACT_NONE;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.act    = ACT_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                cmd.act = ACT_DECODE;
                if (sts.op == OP_TICK) begin
                    if (!sts.cpu_ok)            state_next = S_FINISH;
                    else if (sts.prev_release)  state_next = S_PREV_RD;
                    else if (sts.cur_task)      state_next = S_CUR_RD;
                    else                        state_next = S_WALK_RD;
                end else if (!sts.s_ok) begin
                    state_next = S_FINISH;
                end else begin
                    unique case (sts.op)
                        OP_ADD:    state_next = sts.in_list_s ? S_FINISH : S_ADD;
                        OP_REMOVE: state_next = sts.in_list_s ? S_S_RD : S_FINISH;
                        OP_BLOCK, OP_RUNNABLE, OP_DEAD: state_next = S_S_RD;
                        default:   state_next = S_FINISH;
                    endcase
                end
            end
            S_PREV_RD: begin
                cmd.act    = ACT_PREV_RD;
                state_next = S_PREV_WR;
            end
            S_PREV_WR: begin
                cmd.act    = ACT_PREV_WR;
                state_next = sts.cur_task ? S_CUR_RD : S_WALK_RD;
            end
            S_CUR_RD: begin
                cmd.act    = ACT_CUR_RD;
                state_next = S_CUR_WR;
            end
            S_CUR_WR: begin
                cmd.act    = ACT_CUR_WR;
                state_next = S_WALK_RD;
            end
            S_WALK_RD: begin
                if (!sts.t_valid) begin
                    state_next = S_TICK_END;
                end else begin
                    cmd.act    = ACT_WALK_RD;
                    state_next = S_WALK_CHK;
                end
            end
            S_WALK_CHK: begin
                cmd.act = ACT_WALK_CHK;
                if (sts.walk_found || sts.walk_end) state_next = S_TICK_END;
                else                                state_next = S_WALK_RD;
            end
            S_TICK_END: begin
                cmd.act    = ACT_TICK_END;
                state_next = S_FINISH;
            end
            S_ADD: begin
                cmd.act    = ACT_ADD;
                state_next = S_FINISH;
            end
            S_S_RD: begin
                cmd.act    = ACT_S_RD;
                state_next = (sts.op == OP_REMOVE) ? S_RM_SNEXT : S_MARK_WR;
            end
            S_RM_SNEXT: begin
                cmd.act    = ACT_RM_SNEXT;
                state_next = sts.head_is_s ? S_RM_CLEAR : S_P_RD;
            end
            S_P_RD: begin
                if (!sts.p_valid) begin
                    state_next = S_RM_CLEAR;
                end else begin
                    cmd.act    = ACT_P_RD;
                    state_next = S_P_CHK;
                end
            end
            S_P_CHK: begin
                cmd.act = ACT_P_CHK;
                if (sts.p_hit || sts.p_end) state_next = S_RM_CLEAR;
                else                        state_next = S_P_RD;
            end
            S_RM_CLEAR: begin
                cmd.act    = ACT_RM_CLEAR;
                state_next = S_FINISH;
            end
            S_MARK_WR: begin
                cmd.act    = ACT_MARK_WR;
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (sts.out_free) begin
                    cmd.act    = ACT_RESULT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

/* src/rrts_dp.sv */
module rrts_dp #(
    parameter int NUM_TASKS = 16,
    parameter int NUM_CPUS  = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  rrts_pkg::cmd_t cmd,
    output rrts_pkg::sts_t sts,
    input  logic [2:0]    s_op,
    input  logic [1:0]    s_cpu_id,
    input  logic [3:0]    s_task_id,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [3:0]    m_picked_task,
    output logic          m_picked_idle,
    output logic          m_status
);
    import rrts_pkg::*;

    localparam int SW  = $clog2(NUM_TASKS);
    localparam int CW  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int STW = SW + 1;

    typedef struct packed {
        logic          nv;
        logic [SW-1:0] ns;
        logic [1:0]    st;
        logic          ov;
        logic [CW-1:0] oc;
        logic          os;
    } rec_t;

    localparam int RW = $bits(rec_t);

    // latched request
    op_t           op_reg;
    logic          cpu_ok_reg, s_ok_reg;
    logic [CW-1:0] cpu_reg;
    logic [SW-1:0] s_reg;

    // list and per-cpu state
    logic          head_v_reg;
    logic [SW-1:0] head_s_reg;
    logic [NUM_TASKS-1:0] in_list_reg;
    logic          run_v_reg  [NUM_CPUS];
    logic          run_i_reg  [NUM_CPUS];
    logic [SW-1:0] run_s_reg  [NUM_CPUS];
    logic          prev_v_reg [NUM_CPUS];
    logic          prev_i_reg [NUM_CPUS];
    logic [SW-1:0] prev_s_reg [NUM_CPUS];

    // walk state
    logic           t_v_reg, p_v_reg, sn_v_reg, found_reg;
    logic [SW-1:0]  t_s_reg, start_s_reg, p_s_reg, sn_s_reg;
    logic [STW-1:0] step_reg;

    // result
    logic       res_idle_reg, res_status_reg;
    logic [3:0] res_task_reg;
    logic       m_valid_reg, m_idle_reg, m_status_reg;
    logic [3:0] m_task_reg;

    // ram port
    logic          we;
    logic [SW-1:0] waddr, raddr;
    rec_t          wrec, rec;
    logic [RW-1:0] rdata;

    logic          cur_v, cur_i, prev_v, prev_i, cur_task;
    logic [SW-1:0] cur_s, prev_s;
    logic          nt_v, found_now, nxt_same;
    logic [SW-1:0] nt_s;
    logic [1:0]    mark_st;

    function automatic logic same_who(input logic av, input logic ai,
                                      input logic [SW-1:0] as_,
                                      input logic bv, input logic bi,
                                      input logic [SW-1:0] bs);
        logic r;
        if (av != bv)       r = 1'b0;
        else if (!av)       r = 1'b1;
        else if (ai != bi)  r = 1'b0;
        else                r = ai || (as_ == bs);
        return r;
    endfunction

    rrts_ram #(.WIDTH(RW), .DEPTH(NUM_TASKS)) u_ram (
        .clk   (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wrec),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rec = rec_t'(rdata);

    // current and previous task of the addressed cpu
    assign cur_v    = run_v_reg[cpu_reg];
    assign cur_i    = run_i_reg[cpu_reg];
    assign cur_s    = run_s_reg[cpu_reg];
    assign prev_v   = prev_v_reg[cpu_reg];
    assign prev_i   = prev_i_reg[cpu_reg];
    assign prev_s   = prev_s_reg[cpu_reg];
    assign cur_task = cur_v && !cur_i;

    // round-robin successor, wrapping to the head
    assign nt_v      = rec.nv ? 1'b1 : head_v_reg;
    assign nt_s      = rec.nv ? rec.ns : head_s_reg;
    assign found_now = (rec.st == TS_READY) && !rec.ov && !rec.os;
    assign nxt_same  = same_who(cur_v, cur_i, cur_s, 1'b1, !found_reg,
                                found_reg ? t_s_reg : '0);

    always_comb begin
        unique case (op_reg)
            OP_BLOCK: mark_st = TS_WAIT;
            OP_DEAD:  mark_st = TS_DEAD;
            default:  mark_st = TS_READY;
        endcase
    end

    // status to the controller
    always_comb begin
        sts.op           = op_reg;
        sts.cpu_ok       = cpu_ok_reg;
        sts.s_ok         = s_ok_reg;
        sts.in_list_s    = in_list_reg[s_reg];
        sts.head_is_s    = head_v_reg && (head_s_reg == s_reg);
        sts.prev_release = prev_v && !prev_i &&
                           !same_who(prev_v, prev_i, prev_s, cur_v, cur_i, cur_s);
        sts.cur_task     = cur_task;
        sts.t_valid      = t_v_reg;
        sts.walk_found   = found_now;
        sts.walk_end     = !nt_v || (nt_s == start_s_reg) ||
                           (step_reg == STW'(NUM_TASKS - 1));
        sts.p_valid      = p_v_reg;
        sts.p_hit        = rec.nv && (rec.ns == s_reg);
        sts.p_end        = !rec.nv || (step_reg == STW'(NUM_TASKS - 1));
        sts.out_free     = !m_valid_reg || m_ready;
    end

    // ram read address
    always_comb begin
        unique case (cmd.act)
            ACT_PREV_RD: raddr = prev_s;
            ACT_CUR_RD:  raddr = cur_s;
            ACT_WALK_RD: raddr = t_s_reg;
            ACT_P_RD:    raddr = p_s_reg;
            default:     raddr = s_reg;
        endcase
    end

    // ram writes: read-modify-write on the record just read, or a fresh record on add
    always_comb begin
        we    = 1'b0;
        waddr = s_reg;
        wrec  = rec;
        unique case (cmd.act)
            ACT_PREV_WR: begin
                we      = 1'b1;
                waddr   = prev_s;
                wrec.os = 1'b0;
            end
            ACT_CUR_WR: begin
                we      = 1'b1;
                waddr   = cur_s;
                wrec.ov = 1'b0;
                if (rec.st != TS_WAIT && rec.st != TS_DEAD) wrec.st = TS_READY;
            end
            ACT_WALK_CHK: begin
                we      = found_now;
                waddr   = t_s_reg;
                wrec.ov = 1'b1;
                wrec.oc = cpu_reg;
                wrec.os = 1'b1;
            end
            ACT_ADD: begin
                we      = 1'b1;
                wrec.nv = head_v_reg;
                wrec.ns = head_s_reg;
                wrec.st = TS_READY;
                wrec.ov = 1'b0;
                wrec.oc = '0;
                wrec.os = 1'b0;
            end
            ACT_P_CHK: begin
                we      = rec.nv && (rec.ns == s_reg);
                waddr   = p_s_reg;
                wrec.nv = sn_v_reg;
                wrec.ns = sn_s_reg;
            end
            ACT_MARK_WR: begin
                we      = 1'b1;
                wrec.st = mark_st;
            end
            default: we = 1'b0;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_v_reg  <= 1'b0;
            in_list_reg <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_CPUS; i++) begin
                run_v_reg[i]  <= 1'b0;
                prev_v_reg[i] <= 1'b0;
            end
        end else begin
            unique case (cmd.act)
                ACT_TICK_END: begin
                    run_v_reg[cpu_reg]  <= 1'b1;
                    prev_v_reg[cpu_reg] <= cur_v && !nxt_same;
                end
                ACT_ADD: begin
                    head_v_reg         <= 1'b1;
                    in_list_reg[s_reg] <= 1'b1;
                end
                ACT_RM_SNEXT: begin
                    if (head_v_reg && head_s_reg == s_reg) head_v_reg <= rec.nv;
                end
                ACT_RM_CLEAR: in_list_reg[s_reg] <= 1'b0;
                default: ;
            endcase
            if (cmd.act == ACT_RESULT)  m_valid_reg <= 1'b1;
            else if (m_ready)           m_valid_reg <= 1'b0;
        end
    end

    // payload and walk registers
    always_ff @(posedge aclk) begin
        unique case (cmd.act)
            ACT_LOAD: begin
                op_reg     <= op_t'(s_op);
                cpu_ok_reg <= (32'(s_cpu_id) < 32'(NUM_CPUS));
                cpu_reg    <= (32'(s_cpu_id) < 32'(NUM_CPUS)) ? CW'(s_cpu_id) : '0;
                s_ok_reg   <= (32'(s_task_id) < 32'(NUM_TASKS));
                s_reg      <= (32'(s_task_id) < 32'(NUM_TASKS)) ? SW'(s_task_id) : '0;
            end
            ACT_DECODE: begin
                t_v_reg        <= head_v_reg;
                t_s_reg        <= head_s_reg;
                start_s_reg    <= head_s_reg;
                step_reg       <= '0;
                found_reg      <= 1'b0;
                res_task_reg   <= '0;
                res_idle_reg   <= (op_reg == OP_TICK) && !cpu_ok_reg;
                res_status_reg <= (op_reg != OP_TICK) && s_ok_reg &&
                                  (((op_reg == OP_ADD) && in_list_reg[s_reg]) ||
                                   ((op_reg == OP_REMOVE) && !in_list_reg[s_reg]));
            end
            ACT_CUR_WR: begin
                if (in_list_reg[cur_s] && rec.nv) begin
                    t_v_reg     <= 1'b1;
                    t_s_reg     <= rec.ns;
                    start_s_reg <= rec.ns;
                end
            end
            ACT_WALK_CHK: begin
                if (found_now) begin
                    found_reg <= 1'b1;
                end else begin
                    t_v_reg  <= nt_v;
                    t_s_reg  <= nt_s;
                    step_reg <= step_reg + 1'b1;
                end
            end
            ACT_TICK_END: begin
                run_i_reg[cpu_reg]  <= !found_reg;
                run_s_reg[cpu_reg]  <= found_reg ? t_s_reg : '0;
                prev_i_reg[cpu_reg] <= cur_i;
                prev_s_reg[cpu_reg] <= cur_s;
                res_task_reg        <= found_reg ? 4'(t_s_reg) : 4'd0;
                res_idle_reg        <= !found_reg;
            end
            ACT_ADD: head_s_reg <= s_reg;
            ACT_RM_SNEXT: begin
                sn_v_reg <= rec.nv;
                sn_s_reg <= rec.ns;
                p_v_reg  <= head_v_reg;
                p_s_reg  <= head_s_reg;
                step_reg <= '0;
                if (head_v_reg && head_s_reg == s_reg) head_s_reg <= rec.ns;
            end
            ACT_P_CHK: begin
                p_v_reg  <= rec.nv;
                p_s_reg  <= rec.ns;
                step_reg <= step_reg + 1'b1;
            end
            ACT_RESULT: begin
                m_task_reg   <= res_task_reg;
                m_idle_reg   <= res_idle_reg;
                m_status_reg <= res_status_reg;
            end
            default: ;
        endcase
    end

    assign m_valid       = m_valid_reg;
    assign m_picked_task = m_task_reg;
    assign m_picked_idle = m_idle_reg;
    assign m_status      = m_status_reg;

endmodule

/* src/round_robin_task_scheduler.sv */
// Round-robin task scheduler for NUM_CPUS cpus over a linked table of NUM_TASKS
// task slots, one request at a time, one result per request. Remove searches
// the list for the predecessor, and a scheduling tick walks it for the next
// ready task, up to NUM_TASKS entries. The walk rate is set by the single
// task-table ram: each entry is one registered read and one check. A finished
// result waits in the output register while the next request is taken.
`include "assert_macros.svh"

module round_robin_task_scheduler #(
    parameter int NUM_TASKS = 16,
    parameter int NUM_CPUS  = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_op,
    input  logic [1:0] s_cpu_id,
    input  logic [3:0] s_task_id,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [3:0] m_picked_task,
    output logic       m_picked_idle,
    output logic       m_status
);
    import rrts_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // sequencer
    rrts_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // task table, list and per-cpu state
    rrts_dp #(.NUM_TASKS(NUM_TASKS), .NUM_CPUS(NUM_CPUS)) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .s_op          (s_op),
        .s_cpu_id      (s_cpu_id),
        .s_task_id     (s_task_id),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_picked_task (m_picked_task),
        .m_picked_idle (m_picked_idle),
        .m_status      (m_status)
    );

    // one request in flight at a time
    `ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    // a result is produced only at the end of a request
    `ASSERT_SAME(a_result_from_busy, aclk, aresetn, $rose(m_valid), !$past(s_ready))
    // error status only comes from list edits
    `ASSERT_SAME(a_err_no_pick, aclk, aresetn, m_valid && m_status,
                 !m_picked_idle && (m_picked_task == 4'd0))
    // idle picks report slot zero
    `ASSERT_SAME(a_idle_slot, aclk, aresetn, m_valid && m_picked_idle, m_picked_task == 4'd0)

endmodule

/* tb/sv/tb_round_robin_task_scheduler.sv */
`timescale 1ns / 100ps

module tb_round_robin_task_scheduler;
    import rrts_pkg::*;

    localparam int N_TASKS    = 16;
    localparam int N_CPUS     = 4;
    localparam int N_RANDOM   = 630;
    localparam int CYCLE_CAP  = 400000;
    localparam int DRAIN_WAIT = 60;

    // task table entry link and cpu occupant, as the scheduler codes them
    typedef struct {
        bit       valid;
        bit [3:0] slot;
    } link_t;

    typedef struct {
        bit       valid;
        bit       idle;
        bit [3:0] slot;
    } occupant_t;

    typedef struct {
        bit [3:0] picked_task;
        bit       picked_idle;
        bit       status;
    } pick_t;

    // mirror of the task table with the queue of picks still owed
    class task_table_sb;
        link_t     head;
        link_t     next_link[N_TASKS];
        bit        listed[N_TASKS];
        bit [1:0]  tstat[N_TASKS];
        link_t     owner[N_TASKS];
        bit        stacked[N_TASKS];
        occupant_t running[N_CPUS];
        occupant_t previous[N_CPUS];
        pick_t     owed[$];
        int        errors;
        int        n_ticks;
        int        n_idle;
        int        n_flagged;
        int        n_checked;

        function void clear();
            head = '{0, 0};
            foreach (listed[i]) begin
                listed[i] = 0;
                next_link[i] = '{0, 0};
                tstat[i] = TS_READY;
                owner[i] = '{0, 0};
                stacked[i] = 0;
            end
            foreach (running[i]) begin
                running[i] = '{0, 0, 0};
                previous[i] = '{0, 0, 0};
            end
            owed.delete();
            errors = 0;
            n_ticks = 0;
            n_idle = 0;
            n_flagged = 0;
            n_checked = 0;
        endfunction

        function bit same_occupant(occupant_t a, occupant_t b);
            if (a.valid != b.valid) return 0;
            if (!a.valid) return 1;
            if (a.idle != b.idle) return 0;
            return a.idle || a.slot == b.slot;
        endfunction

        function bit can_run(bit [3:0] s);
            return tstat[s] == TS_READY && !owner[s].valid && !stacked[s];
        endfunction

        function pick_t tick(bit [1:0] c);
            occupant_t cur, prv, nxt;
            link_t     start, t;
            int        steps;
            bit        found;
            pick_t     r;
            cur = running[c];
            prv = previous[c];
            found = 0;
            // release the previous task's stack once it is no longer current
            if (prv.valid && !same_occupant(prv, cur)) begin
                if (!prv.idle) stacked[prv.slot] = 0;
                previous[c].valid = 0;
            end
            if (cur.valid && !cur.idle) begin
                owner[cur.slot].valid = 0;
                if (tstat[cur.slot] != TS_WAIT && tstat[cur.slot] != TS_DEAD)
                    tstat[cur.slot] = TS_READY;
            end
            // round-robin walk from the entry after the current task
            start = head;
            if (cur.valid && !cur.idle && listed[cur.slot] && next_link[cur.slot].valid)
                start = next_link[cur.slot];
            t = start;
            steps = 0;
            while (t.valid && steps < N_TASKS) begin
                if (can_run(t.slot)) begin
                    found = 1;
                    break;
                end
                t = next_link[t.slot].valid ? next_link[t.slot] : head;
                if (t.valid && t.slot == start.slot) break;
                steps++;
            end
            nxt = '{1, !found, found ? t.slot : 4'd0};
            if (found) begin
                owner[t.slot] = '{1, 4'(c)};
                stacked[t.slot] = 1;
            end
            running[c] = nxt;
            if (cur.valid && !same_occupant(cur, nxt)) previous[c] = cur;
            else previous[c].valid = 0;
            r = '{nxt.slot, nxt.idle, 0};
            return r;
        endfunction

        function bit add_task(bit [3:0] s);
            if (listed[s]) return 1;
            tstat[s] = TS_READY;
            owner[s] = '{0, 0};
            stacked[s] = 0;
            next_link[s] = head;
            head = '{1, s};
            listed[s] = 1;
            return 0;
        endfunction

        function bit remove_task(bit [3:0] s);
            link_t p;
            int    steps;
            if (!listed[s]) return 1;
            if (head.valid && head.slot == s) begin
                head = next_link[s];
            end else begin
                // unlink from the predecessor
                p = head;
                for (steps = 0; p.valid && steps < N_TASKS; steps++) begin
                    if (next_link[p.slot].valid && next_link[p.slot].slot == s) begin
                        next_link[p.slot] = next_link[s];
                        break;
                    end
                    p = next_link[p.slot];
                end
            end
            listed[s] = 0;
            return 0;
        endfunction

        function void note_request(op_t op, bit [1:0] c, bit [3:0] s);
            pick_t r;
            r = '{0, 0, 0};
            case (op)
                OP_TICK: begin
                    r = tick(c);
                    n_ticks++;
                    if (r.picked_idle) n_idle++;
                end
                OP_ADD:      r.status = add_task(s);
                OP_REMOVE:   r.status = remove_task(s);
                OP_BLOCK:    tstat[s] = TS_WAIT;
                OP_RUNNABLE: tstat[s] = TS_READY;
                OP_DEAD:     tstat[s] = TS_DEAD;
                default: ;
            endcase
            if (r.status) n_flagged++;
            owed.push_back(r);
        endfunction

        function void check_pick(bit [3:0] pt, bit pi, bit st);
            pick_t e;
            if (owed.size() == 0) begin
                $error("unexpected result: task %0d idle %0d status %0d", pt, pi, st);
                errors++;
                return;
            end
            e = owed.pop_front();
            n_checked++;
            if (pt !== e.picked_task) begin
                $error("picked_task: expected %0d, got %0d", e.picked_task, pt);
                errors++;
            end
            if (pi !== e.picked_idle) begin
                $error("picked_idle: expected %0d, got %0d", e.picked_idle, pi);
                errors++;
            end
            if (st !== e.status) begin
                $error("status: expected %0d, got %0d", e.status, st);
                errors++;
            end
        endfunction
    endclass

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [2:0] s_op;
    logic [1:0] s_cpu_id;
    logic [3:0] s_task_id;
    logic       m_valid;
    logic       m_ready;
    logic [3:0] m_picked_task;
    logic       m_picked_idle;
    logic       m_status;

    task_table_sb sb;
    int           n_accepted;
    int           cycles;

    round_robin_task_scheduler #(
        .NUM_TASKS(N_TASKS),
        .NUM_CPUS (N_CPUS)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_cpu_id     (s_cpu_id),
        .s_task_id    (s_task_id),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_picked_task(m_picked_task),
        .m_picked_idle(m_picked_idle),
        .m_status     (m_status)
    );

    // clock
    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_pick(m_picked_task, m_picked_idle, m_status);
    end

    // receiver: changing stall patterns plus one long hold-off
    initial begin : result_sink
        int  mode;
        int  left;
        bit  held;
        mode = 0;
        left = 0;
        held = 0;
        m_ready <= 1'b0;
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if (!held && n_accepted >= 200) begin
                held = 1;
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 2);
                    left = $urandom_range(20, 120);
                end
                left--;
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(0, 1) == 1);
                    default: m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // offer one request and hold it until taken
    task automatic send_request(op_t op, bit [1:0] c, bit [3:0] s);
        s_valid   <= 1'b1;
        s_op      <= op;
        s_cpu_id  <= c;
        s_task_id <= s;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(op, c, s);
        n_accepted++;
    endtask

    // sender gap after a request, ending a burst now and then
    task automatic maybe_pause(inout int burst);
        int gap;
        if (burst > 0) begin
            burst--;
            return;
        end
        burst = $urandom_range(0, 12);
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    function automatic op_t random_op();
        int w;
        w = $urandom_range(0, 99);
        if (w < 38) return OP_TICK;
        if (w < 54) return OP_ADD;
        if (w < 66) return OP_REMOVE;
        if (w < 76) return OP_BLOCK;
        if (w < 88) return OP_RUNNABLE;
        if (w < 95) return OP_DEAD;
        return (w < 97) ? OP_RSVD6 : OP_RSVD7;
    endfunction

    initial begin : stimulus
        int burst;
        sb = new();
        sb.clear();
        n_accepted = 0;
        burst = 0;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_op      <= OP_TICK;
        s_cpu_id  <= '0;
        s_task_id <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty list, adds at the slot extremes, duplicates, ops on unlisted slots
        send_request(OP_TICK, 2'd3, 4'd0);
        send_request(OP_REMOVE, 2'd0, 4'd7);
        send_request(OP_ADD, 2'd0, 4'd0);
        send_request(OP_ADD, 2'd0, 4'd15);
        send_request(OP_ADD, 2'd0, 4'd5);
        send_request(OP_ADD, 2'd0, 4'd15);
        send_request(OP_BLOCK, 2'd0, 4'd9);
        send_request(OP_TICK, 2'd0, 4'd0);
        send_request(OP_TICK, 2'd1, 4'd15);
        send_request(OP_TICK, 2'd2, 4'd0);
        send_request(OP_TICK, 2'd3, 4'd0);
        send_request(OP_TICK, 2'd0, 4'd0);
        send_request(OP_BLOCK, 2'd0, 4'd0);
        send_request(OP_DEAD, 2'd0, 4'd15);
        send_request(OP_TICK, 2'd1, 4'd0);
        // previous task, its stack still held, removed before its cpu ticks again
        send_request(OP_REMOVE, 2'd0, 4'd5);
        send_request(OP_TICK, 2'd0, 4'd0);
        send_request(OP_RUNNABLE, 2'd0, 4'd0);
        send_request(OP_RSVD6, 2'd2, 4'd10);
        send_request(OP_RSVD7, 2'd1, 4'd3);
        send_request(OP_REMOVE, 2'd0, 4'd0);
        send_request(OP_REMOVE, 2'd0, 4'd0);
        send_request(OP_TICK, 2'd2, 4'd0);

        // random traffic in bursts
        for (int i = 0; i < N_RANDOM; i++) begin
            send_request(random_op(), 2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
            maybe_pause(burst);
        end
        s_valid <= 1'b0;

        while (sb.owed.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("covered %0d requests: %0d ticks (%0d idle), %0d flagged add/remove",
                 n_accepted, sb.n_ticks, sb.n_idle, sb.n_flagged);
        $display("%0d results checked", sb.n_checked);
        if (sb.errors == 0 && sb.owed.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+src
src/rrts_pkg.sv
src/rrts_ram.sv
src/rrts_ctrl.sv
src/rrts_dp.sv
src/round_robin_task_scheduler.sv
tb/sv/tb_round_robin_task_scheduler.sv
